>>> rtl/core/irqfr_pkg.sv
`timescale 1ns / 1ps

package irqfr_pkg;

	localparam int DEF_SLOT_COUNT = 64;

	localparam int DATA_W = 32;
	localparam int FUNC_W = 2;
	localparam int STAT_W = 2;

	localparam logic [FUNC_W-1:0] FN_ENQ  = 2'd0;
	localparam logic [FUNC_W-1:0] FN_DEQ  = 2'd1;
	localparam logic [FUNC_W-1:0] FN_PEEK = 2'd2;
	localparam logic [FUNC_W-1:0] FN_FIND = 2'd3;

	localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
	localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd1;
	localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd2;
	localparam logic [STAT_W-1:0] ST_FULL     = 2'd3;

	typedef struct packed {
		logic flush;
		logic shift;
		logic pop;
		logic push;
	} ctl_t;

endpackage

>>> rtl/core/int_ring_queue_find_remove_top.sv
`timescale 1ns / 1ps

// Queue of signed 32-bit values with enqueue, dequeue, peek and find-and-dequeue, holding
// up to capacity items (at most SLOT_COUNT-1). Items sit in a row of cells, head in the
// first cell; dequeue shifts the row by one. One request is taken at a time. Enqueue,
// dequeue, peek and a find on an empty queue are registered, then carried out in the
// execute state, which loads the result into the output register; the next request is
// taken once the block is back in idle. Find-and-dequeue rotates the occupied cells once
// past the head compare, one cell a cycle, in the scan state and loads its result in the
// finish state. A capacity write empties the queue. Results wait in an output register;
// a stalled result holds the next request at its last step.
module int_ring_queue_find_remove_top #(
	parameter int SLOT_COUNT = irqfr_pkg::DEF_SLOT_COUNT,
	localparam int CNT_W = $clog2(SLOT_COUNT)
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [CNT_W-1:0]                    cfg_wdata,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [irqfr_pkg::FUNC_W-1:0]        func,
	input  logic signed [irqfr_pkg::DATA_W-1:0] value,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [irqfr_pkg::DATA_W-1:0] data,
	output logic [irqfr_pkg::STAT_W-1:0]        status,
	output logic [CNT_W-1:0]                    count,
	output logic                                empty_res
);
	import irqfr_pkg::*;

	localparam int NCELL = SLOT_COUNT - 1;
	localparam logic [CNT_W-1:0] MAXCAP = CNT_W'(SLOT_COUNT - 1);
	localparam logic [CNT_W-1:0] ONE = CNT_W'(1);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_SCAN = 2'd2;
	localparam logic [1:0] S_FIN  = 2'd3;

	logic [1:0]               state_q;
	logic [1:0]               state_d;
	logic [CNT_W-1:0]         cap_q;
	logic [CNT_W-1:0]         cap_eff;
	logic [CNT_W-1:0]         count_q;
	logic [CNT_W-1:0]         step_q;
	logic                     found_q;
	logic signed [DATA_W-1:0] h_q;
	logic [FUNC_W-1:0]        func_q;
	logic signed [DATA_W-1:0] value_q;

	logic                     out_valid_q;
	logic signed [DATA_W-1:0] out_data_q;
	logic [STAT_W-1:0]        out_status_q;
	logic [CNT_W-1:0]         out_count_q;

	ctl_t                     ctl;
	logic                     out_free;
	logic                     out_load;
	logic signed [DATA_W-1:0] res_data;
	logic [STAT_W-1:0]        res_status;
	logic [CNT_W-1:0]         res_count;

	logic                     occ [NCELL+1];
	logic signed [DATA_W-1:0] cell_data [NCELL];
	logic signed [DATA_W-1:0] head;
	logic                     match;
	logic signed [DATA_W-1:0] back;

	assign head  = cell_data[0];
	assign match = (head == value_q);
	assign back  = ((step_q != '0) && match && !found_q) ? h_q : head;

	assign occ[NCELL] = 1'b0;

	genvar gi;
	generate
		for (gi = 0; gi < NCELL; gi++) begin : g_cell
			logic signed [DATA_W-1:0] nxt;
			logic                     prv;
			if (gi == NCELL - 1) begin : g_end
				assign nxt = back;
			end else begin : g_mid
				assign nxt = cell_data[gi+1];
			end
			if (gi == 0) begin : g_first
				assign prv = 1'b1;
			end else begin : g_rest
				assign prv = occ[gi-1];
			end
			irqfr_cell u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.ctl       (ctl),
				.prev_occ  (prv),
				.next_occ  (occ[gi+1]),
				.next_data (nxt),
				.back_data (back),
				.push_data (value_q),
				.occ       (occ[gi]),
				.data      (cell_data[gi])
			);
		end
	endgenerate

	always_comb begin
		if (cap_q == '0) begin
			cap_eff = ONE;
		end else if (cap_q > MAXCAP) begin
			cap_eff = MAXCAP;
		end else begin
			cap_eff = cap_q;
		end
	end

	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		ctl        = '0;
		ctl.flush  = cfg_we;
		out_load   = 1'b0;
		res_data   = '0;
		res_status = ST_OK;
		res_count  = count_q;
		state_d    = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
					case (func_q)
						FN_ENQ: begin
							if (count_q == cap_eff) begin
								res_status = ST_FULL;
							end else begin
								ctl.push  = 1'b1;
								res_count = count_q + ONE;
							end
						end
						FN_DEQ: begin
							if (count_q == '0) begin
								res_status = ST_EMPTY;
							end else begin
								res_data  = head;
								ctl.shift = 1'b1;
								ctl.pop   = 1'b1;
								res_count = count_q - ONE;
							end
						end
						FN_PEEK: begin
							if (count_q == '0) begin
								res_status = ST_EMPTY;
							end else begin
								res_data = head;
							end
						end
						default: begin
							if (count_q == '0) begin
								res_status = ST_NOTFOUND;
							end else begin
								out_load = 1'b0;
								state_d  = S_SCAN;
							end
						end
					endcase
				end
			end
			S_SCAN: begin
				ctl.shift = 1'b1;
				if (step_q == count_q - ONE) begin
					state_d = S_FIN;
				end
			end
			default: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
					if (found_q) begin
						res_data  = value_q;
						ctl.shift = 1'b1;
						ctl.pop   = 1'b1;
						res_count = count_q - ONE;
					end else begin
						res_status = ST_NOTFOUND;
					end
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cap_q       <= '1;
			count_q     <= '0;
			step_q      <= '0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				cap_q   <= cfg_wdata;
				count_q <= '0;
			end else if (out_load) begin
				count_q <= res_count;
			end
			if (state_q == S_SCAN) begin
				step_q  <= step_q + ONE;
				found_q <= found_q | match;
			end else if (state_q != S_FIN) begin
				step_q  <= '0;
				found_q <= 1'b0;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			func_q  <= func;
			value_q <= value;
		end
		if (state_q == S_SCAN && step_q == '0) begin
			h_q <= head;
		end
		if (out_load) begin
			out_data_q   <= res_data;
			out_status_q <= res_status;
			out_count_q  <= res_count;
		end
	end

	assign out_valid = out_valid_q;
	assign data      = out_data_q;
	assign status    = out_status_q;
	assign count     = out_count_q;
	assign empty_res = (out_count_q == '0);

	a_occ_count: assert property (@(posedge clk) disable iff (!arst_n)
		occ[0] == (count_q != '0))
		else $error("head cell occupancy disagrees with count");

	a_scan_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (count_q != '0) && (step_q < count_q))
		else $error("scan running past the occupied cells");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && res_status == ST_FULL) |-> (count_q == cap_eff))
		else $error("full status below capacity");

	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		$past(cfg_we) |-> (count_q == '0) && !occ[0])
		else $error("capacity write did not flush");

endmodule

>>> rtl/core/irqfr_cell.sv
`timescale 1ns / 1ps

module irqfr_cell (
	input  logic                                clk,
	input  logic                                arst_n,
	input  irqfr_pkg::ctl_t                     ctl,
	input  logic                                prev_occ,
	input  logic                                next_occ,
	input  logic signed [irqfr_pkg::DATA_W-1:0] next_data,
	input  logic signed [irqfr_pkg::DATA_W-1:0] back_data,
	input  logic signed [irqfr_pkg::DATA_W-1:0] push_data,
	output logic                                occ,
	output logic signed [irqfr_pkg::DATA_W-1:0] data
);
	import irqfr_pkg::*;

	logic                     occ_q;
	logic signed [DATA_W-1:0] data_q;
	logic                     is_last;
	logic                     first_free;

	assign is_last    = occ_q & ~next_occ;
	assign first_free = ~occ_q & prev_occ;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 1'b0;
		end else if (ctl.flush) begin
			occ_q <= 1'b0;
		end else if (ctl.pop) begin
			occ_q <= next_occ;
		end else if (ctl.push && first_free) begin
			occ_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			data_q <= is_last ? back_data : next_data;
		end else if (ctl.push && first_free) begin
			data_q <= push_data;
		end
	end

	assign occ  = occ_q;
	assign data = data_q;

endmodule
